// ===== hw/rtl/actr_pkg.sv =====
package actr_pkg;

   localparam int unsigned CfgIdxWidth = 3;
   localparam int unsigned CfgDataWidth = 64;

   localparam logic [CfgIdxWidth-1:0] REG_KEY_WORD_0 = 3'd0;
   localparam logic [CfgIdxWidth-1:0] REG_KEY_WORD_1 = 3'd1;
   localparam logic [CfgIdxWidth-1:0] REG_KEY_WORD_2 = 3'd2;
   localparam logic [CfgIdxWidth-1:0] REG_KEY_WORD_3 = 3'd3;
   localparam logic [CfgIdxWidth-1:0] REG_KEY_SIZE_MODE = 3'd4;
   localparam logic [CfgIdxWidth-1:0] REG_NONCE = 3'd5;
   localparam logic [CfgIdxWidth-1:0] REG_START_POSITION = 3'd6;

   localparam logic [1:0] MODE_AES128 = 2'd0;
   localparam logic [1:0] MODE_AES192 = 2'd1;

   // queue entry between classifier and keystream back end
   typedef struct packed {
      logic [7:0]  data;
      logic [59:0] block;
      logic [3:0]  offset;
      logic        regen;
   } job_type;

   typedef logic [7:0] sbox_table_type [256];

   localparam sbox_table_type SBOX = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // one round on a 128-bit state without the round key xor, byte 0 in the top bits
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
      logic [7:0] sb [16];
      logic [7:0] t [16];
      logic [7:0] o [16];
      logic [7:0] all;
      logic [127:0] r;
      for (int i = 0; i < 16; i++) sb[i] = s[127-8*i -: 8];
      for (int c = 0; c < 4; c++)
         for (int i = 0; i < 4; i++)
            t[4*c+i] = SBOX[sb[4*((c+i)%4)+i]];
      for (int c = 0; c < 4; c++) begin
         all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
         for (int i = 0; i < 4; i++)
            o[4*c+i] = last ? t[4*c+i]
                            : t[4*c+i] ^ all ^ xtime(t[4*c+i] ^ t[4*c+(i+1)%4]);
      end
      for (int i = 0; i < 16; i++) r[127-8*i -: 8] = o[i];
      return r;
   endfunction

endpackage

// ===== hw/rtl/actr_front.sv =====
// classifies each byte: does it need a fresh keystream block
module actr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_in_byte,
   input  logic                pos_load,
   input  logic [63:0]         pos_value,
   input  logic                invalidate,
   input  logic                q_full,
   output logic                q_push,
   output actr_pkg::job_type   q_data
);

   logic [63:0] pos_ff, pos_in;
   logic [59:0] blk_ff, blk_in;
   logic        have_ff, have_in;

   assign req_stall = q_full;
   assign q_push = req_valid && !q_full;

   always_comb begin
      q_data.data = req_in_byte;
      q_data.block = pos_ff[63:4];
      q_data.offset = pos_ff[3:0];
      q_data.regen = !have_ff || (blk_ff != pos_ff[63:4]);
   end

   always_comb begin
      pos_in = pos_ff;
      blk_in = blk_ff;
      have_in = have_ff;
      if (q_push) begin
         pos_in = pos_ff + 64'd1;
         blk_in = pos_ff[63:4];
         have_in = 1'b1;
      end
      if (pos_load) pos_in = pos_value;
      if (invalidate) have_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         blk_ff <= '0;
         have_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         blk_ff <= blk_in;
         have_ff <= have_in;
      end
   end

endmodule

// ===== hw/rtl/actr_queue.sv =====
module actr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  actr_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output actr_pkg::job_type pop_data
);

   actr_pkg::job_type mem_ff [2];
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      rd_in = rd_ff ^ pop;
      wr_in = wr_ff ^ push;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== hw/rtl/actr_keysched.sv =====
// key expansion, one word per cycle into a 60-entry memory
module actr_keysched (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] key_word_0,
   input  logic [63:0] key_word_1,
   input  logic [63:0] key_word_2,
   input  logic [63:0] key_word_3,
   input  logic [1:0]  key_size_mode,
   output logic        busy,
   input  logic [5:0]  rd_addr,
   output logic [31:0] rd_data
);

   logic [31:0] rk_mem [60];
   logic [31:0] win_ff [8], win_in [8];
   logic [5:0]  idx_ff, idx_in;
   logic [2:0]  ph_ff, ph_in;
   logic [7:0]  rc_ff, rc_in;
   logic        busy_ff, busy_in;
   logic [3:0]  nk;
   logic [2:0]  nk_last;
   logic [5:0]  total;
   logic [31:0] t, w_new, wr_data;
   logic [255:0] key;
   logic        loading;

   always_comb begin
      unique case (key_size_mode)
         actr_pkg::MODE_AES128: begin nk = 4'd4; total = 6'd44; end
         actr_pkg::MODE_AES192: begin nk = 4'd6; total = 6'd52; end
         default:               begin nk = 4'd8; total = 6'd60; end
      endcase
      nk_last = 3'(nk - 4'd1);
      key = {key_word_0, key_word_1, key_word_2, key_word_3};
   end

   assign busy = busy_ff;

   // win_ff[0] holds w[i-nk] ... win_ff[nk-1] holds w[i-1]
   // the key words are copied into memory first, one per cycle
   always_comb begin
      loading = idx_ff < {2'd0, nk};
      t = win_ff[nk_last];
      if (ph_ff == 3'd0) t = actr_pkg::sub_word({t[23:0], t[31:24]}) ^ {rc_ff, 24'd0};
      else if (nk == 4'd8 && ph_ff == 3'd4) t = actr_pkg::sub_word(t);
      w_new = win_ff[0] ^ t;
      wr_data = loading ? win_ff[idx_ff[2:0]] : w_new;
      for (int k = 0; k < 8; k++) win_in[k] = win_ff[k];
      idx_in = idx_ff;
      ph_in = ph_ff;
      rc_in = rc_ff;
      busy_in = busy_ff;
      if (start) begin
         for (int k = 0; k < 8; k++) win_in[k] = key[255-32*k -: 32];
         idx_in = 6'd0;
         ph_in = 3'd0;
         rc_in = 8'h01;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         idx_in = idx_ff + 6'd1;
         if (!loading) begin
            for (int k = 0; k < 7; k++) win_in[k] = win_ff[k+1];
            win_in[nk_last] = w_new;
            if (ph_ff == nk_last) begin
               ph_in = 3'd0;
               rc_in = actr_pkg::xtime(rc_ff);
            end else begin
               ph_in = ph_ff + 3'd1;
            end
         end
         if (idx_ff == total - 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff && !start) begin
         rk_mem[idx_ff] <= wr_data;
      end
      rd_data <= rk_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 8; k++) win_ff[k] <= win_in[k];
      if (reset) begin
         idx_ff <= '0;
         ph_ff <= '0;
         rc_ff <= 8'h01;
         busy_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         ph_ff <= ph_in;
         rc_ff <= rc_in;
         busy_ff <= busy_in;
      end
   end

endmodule

// ===== hw/rtl/actr_back.sv =====
// iterative aes core: one round at a time, then streams bytes from the block buffer
module actr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  actr_pkg::job_type q_data,
   output logic              q_pop,
   input  logic              ks_busy,
   input  logic [63:0]       nonce,
   input  logic [1:0]        key_size_mode,
   output logic [5:0]        rk_addr,
   input  logic [31:0]       rk_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FETCH = 4'b0010,
      ST_ROUND = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type   st_ff, st_in;
   logic [127:0] s_ff, s_in, blk_ff, blk_in;
   logic [3:0]  rnd_ff, rnd_in, nr;
   logic [1:0]  col_ff, col_in;
   logic [127:0] rk_ff, rk_in;
   logic        ov_ff, ov_in;
   logic [7:0]  ob_ff, ob_in;
   logic        out_free;
   logic [127:0] rnd_out;

   always_comb begin
      unique case (key_size_mode)
         actr_pkg::MODE_AES128: nr = 4'd10;
         actr_pkg::MODE_AES192: nr = 4'd12;
         default:               nr = 4'd14;
      endcase
   end

   assign out_free = !ov_ff || !rsp_stall;
   assign rsp_valid = ov_ff;
   assign rsp_out_byte = ob_ff;
   assign rnd_out = actr_pkg::aes_round(s_ff, rnd_ff == nr);
   // word address: round*4 + column
   assign rk_addr = {rnd_ff, col_ff};

   always_comb begin
      st_in = st_ff;
      s_in = s_ff;
      blk_in = blk_ff;
      rnd_in = rnd_ff;
      col_in = col_ff;
      rk_in = rk_ff;
      ov_in = ov_ff && rsp_stall;
      ob_in = ob_ff;
      q_pop = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (q_not_empty && !ks_busy) begin
               if (q_data.regen) begin
                  s_in = {nonce, 4'd0, q_data.block};
                  rnd_in = 4'd0;
                  col_in = 2'd0;
                  st_in = ST_FETCH;
               end else begin
                  st_in = ST_EMIT;
               end
            end
         end
         // four reads, data lands in the next cycle; col wraps to zero after four
         ST_FETCH: begin
            col_in = col_ff + 2'd1;
            if (col_ff == 2'd3) st_in = ST_ROUND;
         end
         ST_ROUND: begin
            // collect last word, then apply
            if (rnd_ff == 4'd0) s_in = s_ff ^ {rk_ff[95:0], rk_data};
            else s_in = rnd_out ^ {rk_ff[95:0], rk_data};
            if (rnd_ff == nr) begin
               blk_in = s_in;
               st_in = ST_EMIT;
            end else begin
               rnd_in = rnd_ff + 4'd1;
               st_in = ST_FETCH;
            end
         end
         default: begin
            if (out_free) begin
               ov_in = 1'b1;
               ob_in = q_data.data ^ blk_ff[127-8*q_data.offset -: 8];
               q_pop = 1'b1;
               st_in = ST_IDLE;
            end
         end
      endcase
      if (st_ff == ST_FETCH && col_ff != 2'd0) rk_in = {rk_ff[95:0], rk_data};
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in;
      blk_ff <= blk_in;
      rk_ff <= rk_in;
      ob_ff <= ob_in;
      if (reset) begin
         st_ff <= ST_IDLE;
         rnd_ff <= '0;
         col_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         rnd_ff <= rnd_in;
         col_ff <= col_in;
         ov_ff <= ov_in;
      end
   end

endmodule

// ===== hw/rtl/aes_counter_mode_stream_xor_top.sv =====
// aes counter mode byte stream xor
// req channel: one byte per transaction (req_valid / req_stall); rsp channel
// returns that byte xor the keystream byte at the current stream position.
// csr port: csr_write with csr_index 0..6 (key words 0-3, key size mode,
// nonce, start position); writing start position seeks the stream.
// a front stage tracks the position and flags block changes, a two-entry
// queue decouples it from the back end, which holds one iterative aes core.
// a byte inside the cached block reuses the buffered keystream; a new block
// is computed by the single round unit, which reads one round key word per
// cycle from the key schedule memory. the back end takes the next byte only
// once the result for the previous one has been emitted.
// after reset and after each key or mode write the key schedule is expanded
// at one word per cycle into up to 60 words; processing waits for it.
// reset zeroes the configuration and position registers and invalidates the cached block.
// when rsp_stall is high the result is held, the queue fills and req_stall
// rises once both queue entries are occupied.
module aes_counter_mode_stream_xor_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   input  logic        csr_write,
   input  logic [actr_pkg::CfgIdxWidth-1:0]  csr_index,
   input  logic [actr_pkg::CfgDataWidth-1:0] csr_data
);

   logic [63:0] kw0_ff, kw1_ff, kw2_ff, kw3_ff, nonce_ff, start_ff;
   logic [1:0]  mode_ff;
   logic        key_wr, nonce_wr, pos_wr, init_ff;
   logic        q_full, q_push, q_pop, q_ne, ks_busy;
   actr_pkg::job_type q_in, q_out;
   logic [5:0]  rk_addr;
   logic [31:0] rk_data;

   always_comb begin
      key_wr = 1'b0;
      nonce_wr = 1'b0;
      pos_wr = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            actr_pkg::REG_KEY_WORD_0, actr_pkg::REG_KEY_WORD_1,
            actr_pkg::REG_KEY_WORD_2, actr_pkg::REG_KEY_WORD_3,
            actr_pkg::REG_KEY_SIZE_MODE: key_wr = 1'b1;
            actr_pkg::REG_NONCE: nonce_wr = 1'b1;
            actr_pkg::REG_START_POSITION: pos_wr = 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kw0_ff <= '0; kw1_ff <= '0; kw2_ff <= '0; kw3_ff <= '0;
         nonce_ff <= '0; start_ff <= '0; mode_ff <= '0;
         init_ff <= 1'b1;
      end else begin
         init_ff <= 1'b0;
         if (csr_write) begin
            unique case (csr_index)
               actr_pkg::REG_KEY_WORD_0: kw0_ff <= csr_data;
               actr_pkg::REG_KEY_WORD_1: kw1_ff <= csr_data;
               actr_pkg::REG_KEY_WORD_2: kw2_ff <= csr_data;
               actr_pkg::REG_KEY_WORD_3: kw3_ff <= csr_data;
               actr_pkg::REG_KEY_SIZE_MODE: mode_ff <= csr_data[1:0];
               actr_pkg::REG_NONCE: nonce_ff <= csr_data;
               actr_pkg::REG_START_POSITION: start_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   logic ks_start_ff;
   always_ff @(posedge clock) begin
      if (reset) ks_start_ff <= 1'b0;
      else ks_start_ff <= key_wr || init_ff;
   end

   actr_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_in_byte,
      .pos_load(pos_wr), .pos_value(csr_data),
      .invalidate(key_wr || nonce_wr),
      .q_full, .q_push, .q_data(q_in)
   );

   actr_queue u_queue (
      .clock, .reset, .push(q_push), .push_data(q_in), .full(q_full),
      .pop(q_pop), .not_empty(q_ne), .pop_data(q_out)
   );

   actr_keysched u_ks (
      .clock, .reset, .start(ks_start_ff),
      .key_word_0(kw0_ff), .key_word_1(kw1_ff), .key_word_2(kw2_ff),
      .key_word_3(kw3_ff), .key_size_mode(mode_ff), .busy(ks_busy),
      .rd_addr(rk_addr), .rd_data(rk_data)
   );

   actr_back u_back (
      .clock, .reset, .q_not_empty(q_ne), .q_data(q_out), .q_pop,
      .ks_busy(ks_busy || ks_start_ff), .nonce(nonce_ff),
      .key_size_mode(mode_ff), .rk_addr, .rk_data,
      .rsp_valid, .rsp_stall, .rsp_out_byte
   );

   logic unused_start;
   assign unused_start = ^start_ff;

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push) else $error("push into full queue");
   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_ne) else $error("pop from empty queue");
   a_pop_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid) else $error("pop without result");

endmodule

// ===== test/aes_counter_mode_stream_xor_checker.sv =====
module aes_counter_mode_stream_xor_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_byte,
   input  logic        csr_write,
   input  logic [actr_pkg::CfgIdxWidth-1:0]  csr_index,
   input  logic [actr_pkg::CfgDataWidth-1:0] csr_data,
   output int          fail_count,
   output int          pending_bytes
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [63:0] key_reg [4];
   logic [1:0]  key_mode;
   logic [63:0] nonce_reg;
   logic [63:0] position;
   logic [31:0] schedule [60];
   int unsigned round_count;
   logic [127:0] cached_block;
   logic [59:0]  cached_index;
   logic         cached_ok;
   logic [7:0]   expected_bytes [$];

   localparam logic [7:0] RCON [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                         8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

   function automatic logic [7:0] sbox_of(input logic [7:0] b);
      return actr_pkg::SBOX[b];
   endfunction

   function automatic logic [31:0] subst_word(input logic [31:0] w);
      return {sbox_of(w[31:24]), sbox_of(w[23:16]), sbox_of(w[15:8]), sbox_of(w[7:0])};
   endfunction

   function automatic logic [7:0] gf_double(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   task automatic expand_schedule();
      int unsigned nk, total;
      logic [31:0] t;
      logic [1:0] m;
      m = (key_mode == 2'd3) ? 2'd2 : key_mode;
      nk = 4 + 2 * m;
      round_count = nk + 6;
      total = 4 * (round_count + 1);
      for (int i = 0; i < nk; i++)
         schedule[i] = (i % 2) ? key_reg[i/2][31:0] : key_reg[i/2][63:32];
      for (int i = nk; i < total; i++) begin
         t = schedule[i-1];
         if (i % nk == 0)
            t = subst_word({t[23:0], t[31:24]}) ^ {RCON[(i/nk - 1) % 10], 24'h0};
         else if (nk > 6 && i % nk == 4)
            t = subst_word(t);
         schedule[i] = schedule[i-nk] ^ t;
      end
   endtask

   function automatic logic [127:0] encrypt_counter(input logic [59:0] blk);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, all;
      logic [63:0] ctr;
      logic [127:0] r;
      ctr = {4'h0, blk};
      for (int i = 0; i < 8; i++) begin
         s[i] = nonce_reg[63-8*i -: 8];
         s[8+i] = ctr[63-8*i -: 8];
      end
      for (int rnd = 0; rnd <= round_count; rnd++) begin
         if (rnd > 0) begin
            for (int c = 0; c < 4; c++)
               for (int i = 0; i < 4; i++)
                  t[4*c+i] = sbox_of(s[4*((c+i)%4)+i]);
            for (int c = 0; c < 4; c++) begin
               a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
               if (rnd != round_count) begin
                  all = a0 ^ a1 ^ a2 ^ a3;
                  s[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
                  s[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
                  s[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
                  s[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
               end else begin
                  s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
               end
            end
         end
         for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
               s[4*c+i] ^= schedule[rnd*4+c][31-8*i -: 8];
      end
      for (int i = 0; i < 16; i++) r[127-8*i -: 8] = s[i];
      return r;
   endfunction

   always @(posedge clock) begin
      logic [7:0] want;
      if (reset) begin
         for (int i = 0; i < 4; i++) key_reg[i] = '0;
         key_mode = actr_pkg::MODE_AES128;
         nonce_reg = '0;
         position = '0;
         cached_ok = 1'b0;
         cached_index = '0;
         expected_bytes.delete();
         fail_count = 0;
         expand_schedule();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected out_byte %02h", $realtime, rsp_out_byte);
               fail_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want) begin
                  $display("%0t: out_byte expected %02h actual %02h",
                           $realtime, want, rsp_out_byte);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (!cached_ok || cached_index != position[63:4]) begin
               cached_block = encrypt_counter(position[63:4]);
               cached_index = position[63:4];
               cached_ok = 1'b1;
            end
            expected_bytes.push_back(req_in_byte ^ cached_block[127-8*position[3:0] -: 8]);
            position = position + 64'd1;
         end
         if (csr_write) begin
            case (csr_index)
               actr_pkg::REG_KEY_WORD_0, actr_pkg::REG_KEY_WORD_1,
               actr_pkg::REG_KEY_WORD_2, actr_pkg::REG_KEY_WORD_3: begin
                  key_reg[csr_index[1:0]] = csr_data;
                  expand_schedule();
                  cached_ok = 1'b0;
               end
               actr_pkg::REG_KEY_SIZE_MODE: begin
                  key_mode = csr_data[1:0];
                  expand_schedule();
                  cached_ok = 1'b0;
               end
               actr_pkg::REG_NONCE: begin
                  nonce_reg = csr_data;
                  cached_ok = 1'b0;
               end
               actr_pkg::REG_START_POSITION: position = csr_data;
               default: ;
            endcase
         end
      end
      pending_bytes = expected_bytes.size();
   end
endmodule

// ===== test/aes_counter_mode_stream_xor_top_tb.sv =====
module aes_counter_mode_stream_xor_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [actr_pkg::CfgIdxWidth-1:0] REG_OUT_OF_RANGE = 3'd7;
   localparam int IdleLimit = 20000;
   localparam int LatencyCycles = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_in_byte = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic csr_write = 1'b0;
   logic [actr_pkg::CfgIdxWidth-1:0] csr_index = '0;
   logic [actr_pkg::CfgDataWidth-1:0] csr_data = '0;
   int fail_count;
   int pending_bytes;
   int idle_cycles = 0;
   logic stall_gaps = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   aes_counter_mode_stream_xor_top DUT (.*);

   aes_counter_mode_stream_xor_checker checker_i (.*);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("aes_counter_mode_stream_xor_top_tb NOT OK");
         $finish;
      end
   end

   function automatic int gap_length();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // receiver back-pressure
   always @(negedge clock) begin
      if (!stall_gaps) rsp_stall <= 1'b0;
      else if (rsp_stall) rsp_stall <= ($urandom_range(0, 9) < 7);
      else rsp_stall <= ($urandom_range(0, 24) == 0)
                        || ($urandom_range(0, 5) == 0);
   end

   // valid stays high after the last transaction until the caller drops it
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = gap_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_bytes != 0) @(negedge clock);
      repeat (LatencyCycles) @(negedge clock);
   endtask

   task automatic write_reg(input logic [actr_pkg::CfgIdxWidth-1:0] idx,
                            input logic [63:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_key(input logic [1:0] mode);
      write_reg(actr_pkg::REG_KEY_WORD_0, {$urandom, $urandom});
      write_reg(actr_pkg::REG_KEY_WORD_1, {$urandom, $urandom});
      write_reg(actr_pkg::REG_KEY_WORD_2, {$urandom, $urandom});
      write_reg(actr_pkg::REG_KEY_WORD_3, {$urandom, $urandom});
      write_reg(actr_pkg::REG_KEY_SIZE_MODE, {62'd0, mode});
      write_reg(actr_pkg::REG_NONCE, {$urandom, $urandom});
   endtask

   task automatic stream_burst(input int count);
      for (int i = 0; i < count; i++) send_byte(8'($urandom_range(0, 255)));
   endtask

   initial begin
      logic [63:0] seek;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      // raw keystream with all-zero key at reset, then extremes
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'h55);
      send_byte(8'haa);
      drain();
      // fips-197 style all-ones key, mode 3 saturates to 256 bit
      write_reg(actr_pkg::REG_KEY_WORD_0, '1);
      write_reg(actr_pkg::REG_KEY_WORD_1, '1);
      write_reg(actr_pkg::REG_KEY_WORD_2, '1);
      write_reg(actr_pkg::REG_KEY_WORD_3, '1);
      write_reg(actr_pkg::REG_KEY_SIZE_MODE, 64'd3);
      write_reg(actr_pkg::REG_NONCE, '1);
      write_reg(actr_pkg::REG_START_POSITION, 64'hffff_ffff_ffff_fffc);
      for (int i = 0; i < 8; i++) send_byte(8'h00); // crosses position wrap
      drain();
      write_reg(REG_OUT_OF_RANGE, 64'h1234);
      write_reg(actr_pkg::REG_KEY_SIZE_MODE, {62'd0, actr_pkg::MODE_AES192});
      write_reg(actr_pkg::REG_START_POSITION, 64'h0);
      for (int i = 0; i < 6; i++) send_byte(8'hff);
      drain();
      // key change mid-stream keeps position
      write_reg(actr_pkg::REG_NONCE, 64'h0);
      write_reg(actr_pkg::REG_KEY_SIZE_MODE, {62'd0, actr_pkg::MODE_AES128});
      for (int i = 0; i < 6; i++) send_byte(8'($urandom_range(0, 255)));
      drain();
      for (int phase = 0; phase < 12; phase++) begin
         load_key(phase % 3 == 0 ? 2'd3 : 2'($urandom_range(0, 2)));
         case ($urandom_range(0, 3))
            0: seek = 64'h0;
            1: seek = 64'hffff_ffff_ffff_ff00 | 64'($urandom_range(0, 255));
            default: seek = {$urandom, $urandom};
         endcase
         write_reg(actr_pkg::REG_START_POSITION, seek);
         stall_gaps = (phase % 4 != 1);
         stream_burst(130);
         if (phase == 5) begin
            // hold off until everything expected is back
            req_valid <= 1'b0;
            while (pending_bytes != 0) @(negedge clock);
            stream_burst(10);
         end
         drain();
      end
      stall_gaps = 1'b1;
      drain();
      if (fail_count == 0)
         $display("aes_counter_mode_stream_xor_top_tb OK");
      else
         $display("aes_counter_mode_stream_xor_top_tb NOT OK");
      $finish;
   end
endmodule
